### src/can_fast_packet_reassembler_macros.svh
// ============================================================================
// CAN fast-packet reassembler assertion macros
// Shared concurrent assertion forms for the reassembler modules.
// ============================================================================
`ifndef CAN_FAST_PACKET_REASSEMBLER_MACROS_SVH
`define CAN_FAST_PACKET_REASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cfpr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cfpr: assertion failed");

`endif

### src/cfpr_pkg.sv
// ============================================================================
// CAN fast-packet reassembler package
// Types, constants and the fast-packet PGN list shared by the modules.
// ============================================================================
`timescale 1ns / 1ps

package cfpr_pkg;

    // Default sizes.
    localparam int CFPR_BUF_DEPTH      = 256;
    localparam int CFPR_FAST_LIST_SIZE = 17;

    // Wide address used for buffer bounds checks (covers depths below 4096).
    localparam int CFPR_XW = 12;

    // Field widths.
    localparam int CFPR_PGN_W = 19;
    localparam int CFPR_CNT_W = 32;

    // Frame constants.
    localparam logic [3:0] CFPR_MAX_LEN  = 4'd9;
    localparam logic [4:0] CFPR_SEQ_MASK = 5'h1f;

    // Fixed list of PGNs that travel as fast packets.
    localparam int CFPR_TABLE_LEN = 17;
    localparam logic [CFPR_PGN_W-1:0] CFPR_FAST_PGNS [CFPR_TABLE_LEN] = '{
        19'd126464, 19'd126996, 19'd127489, 19'd128275, 19'd129540, 19'd129542,
        19'd129793, 19'd129794, 19'd129798, 19'd129802, 19'd129809, 19'd129810,
        19'd130935, 19'd130842, 19'd262161, 19'd262384, 19'd262386
    };

    // Item action codes.
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Message assembly status.
    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_ERROR      = 2'd1,
        ST_INCOMPLETE = 2'd2
    } t_asm_st;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_CHECK,
        S_READ,
        S_DONE
    } t_state;

    // Kind of frame being stored.
    typedef enum logic [1:0] {
        K_START,
        K_CONT,
        K_SINGLE
    } t_kind;

    // Buffer port request from the sequencer.
    typedef struct packed {
        logic               we;
        logic [CFPR_XW-1:0] waddr;
        logic [7:0]         wdata;
        logic [CFPR_XW-1:0] raddr;
    } t_buf_req;

    // One result item.
    typedef struct packed {
        logic [CFPR_CNT_W-1:0] cancels;
        logic [CFPR_CNT_W-1:0] errors;
        logic [CFPR_CNT_W-1:0] messages;
        logic [CFPR_CNT_W-1:0] frames;
        logic [7:0]            read_byte;
        logic [7:0]            msg_len;
        logic [CFPR_PGN_W-1:0] msg_pgn;
        logic [1:0]            msg_status;
    } t_result;

endpackage

### src/cfpr_buf.sv
// ============================================================================
// CAN fast-packet reassembler message buffer
// Single-port-write, registered-read byte memory for reassembled messages.
// ============================================================================
`timescale 1ns / 1ps

module cfpr_buf #(
    parameter int BUF_DEPTH = cfpr_pkg::CFPR_BUF_DEPTH
) (
    input  logic              i_clk,
    input  cfpr_pkg::t_buf_req i_req,
    output logic [7:0]        o_rd_data
);
    import cfpr_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    // Byte write, gated by the sequencer's bounds check.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/cfpr_seq.sv
// ============================================================================
// CAN fast-packet reassembler sequencer
// Classifies each frame and stores its bytes one per cycle through a shared
// pointer increment and compare unit; keeps the message state and counters.
// ============================================================================
`timescale 1ns / 1ps
`include "can_fast_packet_reassembler_macros.svh"

module cfpr_seq #(
    parameter int BUF_DEPTH      = cfpr_pkg::CFPR_BUF_DEPTH,
    parameter int FAST_LIST_SIZE = cfpr_pkg::CFPR_FAST_LIST_SIZE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item start
    input  logic                              i_start,
    input  logic                              i_action,
    input  logic [cfpr_pkg::CFPR_PGN_W-1:0]   i_frame_pgn,
    input  logic [3:0]                        i_frame_len,
    input  logic [63:0]                       i_payload,
    input  logic [7:0]                        i_ninth_byte,
    input  logic [7:0]                        i_read_index,
    output logic                              o_ready,
    // Result handoff
    output logic                              o_res_valid,
    input  logic                              i_res_ack,
    output cfpr_pkg::t_result                 o_res,
    // Buffer port
    output cfpr_pkg::t_buf_req                o_buf,
    input  logic [7:0]                        i_rd_data
);
    import cfpr_pkg::*;

    localparam logic [CFPR_XW-1:0] DEPTH_X = CFPR_XW'(BUF_DEPTH);

    // Control state.
    t_state                r_state, n_state;
    t_asm_st               r_ast, n_ast;
    t_kind                 r_kind, n_kind;
    logic [8:0]            r_exp, n_exp;
    logic [8:0]            r_ptr, n_ptr;
    logic [7:0]            r_ann, n_ann;
    logic [7:0]            r_dlen, n_dlen;
    logic [CFPR_PGN_W-1:0] r_dpgn, n_dpgn;
    logic [CFPR_CNT_W-1:0] r_frames, n_frames;
    logic [CFPR_CNT_W-1:0] r_msgs, n_msgs;
    logic [CFPR_CNT_W-1:0] r_errs, n_errs;
    logic [CFPR_CNT_W-1:0] r_cancels, n_cancels;
    logic [3:0]            r_bidx, n_bidx;
    logic [3:0]            r_bend, n_bend;

    // Captured item.
    logic                  r_action;
    logic [CFPR_PGN_W-1:0] r_pgn;
    logic [3:0]            r_len;
    logic [7:0]            r_bytes [9];
    logic [7:0]            r_idx;

    logic                  is_fast;
    logic                  cancel_hit;
    logic                  do_store;
    logic [7:0]            seq0;
    logic                  rd_ok;

    // Capture the item at accept; the length is clamped to nine bytes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_action <= i_action;
            r_pgn    <= i_frame_pgn;
            r_len    <= (i_frame_len > CFPR_MAX_LEN) ? CFPR_MAX_LEN : i_frame_len;
            for (int i = 0; i < 8; i++) begin
                r_bytes[i] <= i_payload[8*i +: 8];
            end
            r_bytes[8] <= i_ninth_byte;
            r_idx      <= i_read_index;
        end
    end

    // Fast-packet list match over independent entries.
    always_comb begin
        is_fast = 1'b0;
        for (int i = 0; i < CFPR_TABLE_LEN; i++) begin
            if (i < FAST_LIST_SIZE && CFPR_FAST_PGNS[i] == r_pgn) begin
                is_fast = 1'b1;
            end
        end
    end

    assign seq0       = r_bytes[0];
    assign cancel_hit = (r_dpgn == '0) && (r_ast == ST_INCOMPLETE);
    assign do_store   = (r_kind != K_CONT) || ({1'b0, r_ann} > r_ptr);
    assign rd_ok      = {{(CFPR_XW-8){1'b0}}, r_idx} < DEPTH_X;

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ast     <= ST_COMPLETE;
            r_kind    <= K_SINGLE;
            r_exp     <= '0;
            r_ptr     <= '0;
            r_ann     <= '0;
            r_dlen    <= '0;
            r_dpgn    <= '0;
            r_frames  <= '0;
            r_msgs    <= '0;
            r_errs    <= '0;
            r_cancels <= '0;
            r_bidx    <= '0;
            r_bend    <= '0;
        end else begin
            r_state   <= n_state;
            r_ast     <= n_ast;
            r_kind    <= n_kind;
            r_exp     <= n_exp;
            r_ptr     <= n_ptr;
            r_ann     <= n_ann;
            r_dlen    <= n_dlen;
            r_dpgn    <= n_dpgn;
            r_frames  <= n_frames;
            r_msgs    <= n_msgs;
            r_errs    <= n_errs;
            r_cancels <= n_cancels;
            r_bidx    <= n_bidx;
            r_bend    <= n_bend;
        end
    end

    // Next state, message bookkeeping and buffer port.
    always_comb begin
        n_state   = r_state;
        n_ast     = r_ast;
        n_kind    = r_kind;
        n_exp     = r_exp;
        n_ptr     = r_ptr;
        n_ann     = r_ann;
        n_dlen    = r_dlen;
        n_dpgn    = r_dpgn;
        n_frames  = r_frames;
        n_msgs    = r_msgs;
        n_errs    = r_errs;
        n_cancels = r_cancels;
        n_bidx    = r_bidx;
        n_bend    = r_bend;

        o_buf.we    = 1'b0;
        o_buf.waddr = {{(CFPR_XW-9){1'b0}}, r_ptr};
        o_buf.wdata = r_bytes[r_bidx];
        o_buf.raddr = {{(CFPR_XW-8){1'b0}}, r_idx};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_action == ACT_READ) ? S_READ : S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_frames = r_frames + 1'b1;
                if (is_fast && r_len == CFPR_MAX_LEN) begin
                    if ((seq0[4:0] & CFPR_SEQ_MASK) == '0) begin
                        // Start of a new fast message.
                        if (cancel_hit) begin
                            n_cancels = r_cancels + 1'b1;
                        end
                        n_ann   = r_bytes[1];
                        n_exp   = {1'b0, seq0} + 9'd1;
                        n_ptr   = '0;
                        n_dpgn  = '0;
                        n_ast   = ST_INCOMPLETE;
                        n_kind  = K_START;
                        n_bidx  = 4'd2;
                        n_bend  = 4'd7;
                        n_state = S_WRITE;
                    end else if ({1'b0, seq0} == r_exp) begin
                        // Expected continuation.
                        n_ast   = ST_INCOMPLETE;
                        n_kind  = K_CONT;
                        n_bidx  = 4'd1;
                        n_bend  = 4'd7;
                        n_state = S_WRITE;
                    end else begin
                        // Out-of-sequence fast frame.
                        n_exp   = '0;
                        n_ann   = '0;
                        n_ast   = ST_ERROR;
                        n_errs  = r_errs + 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    // Single frame stored whole.
                    if (cancel_hit) begin
                        n_cancels = r_cancels + 1'b1;
                    end
                    n_ptr   = '0;
                    n_exp   = '0;
                    n_dlen  = {4'd0, r_len};
                    n_ann   = '0;
                    n_dpgn  = r_pgn;
                    n_ast   = ST_COMPLETE;
                    n_msgs  = r_msgs + 1'b1;
                    n_kind  = K_SINGLE;
                    n_bidx  = '0;
                    n_bend  = r_len - 4'd1;
                    n_state = (r_len == '0) ? S_DONE : S_WRITE;
                end
            end

            S_WRITE: begin
                // One byte per cycle; bytes past the buffer end are dropped.
                if (do_store) begin
                    o_buf.we = ({{(CFPR_XW-9){1'b0}}, r_ptr} < DEPTH_X);
                    n_ptr    = r_ptr + 9'd1;
                end
                n_bidx = r_bidx + 4'd1;
                if (r_bidx == r_bend) begin
                    n_state = (r_kind == K_CONT) ? S_CHECK : S_DONE;
                end
            end

            S_CHECK: begin
                // Continuation completes the message when the pointer meets the length.
                if (r_ptr == {1'b0, r_ann}) begin
                    n_dlen = r_ann;
                    n_ann  = '0;
                    n_dpgn = r_pgn;
                    n_ast  = ST_COMPLETE;
                    n_msgs = r_msgs + 1'b1;
                end else begin
                    n_exp = r_exp + 9'd1;
                end
                n_state = S_DONE;
            end

            S_READ: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields reflect the state after the item.
    always_comb begin
        o_res            = '0;
        o_res.msg_status = r_ast;
        o_res.msg_pgn    = r_dpgn;
        o_res.msg_len    = r_dlen;
        o_res.read_byte  = (r_action == ACT_READ && rd_ok) ? i_rd_data : 8'd0;
        o_res.frames     = r_frames;
        o_res.messages   = r_msgs;
        o_res.errors     = r_errs;
        o_res.cancels    = r_cancels;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    // Buffer writes happen only while storing frame bytes.
    `CFPR_ASSERT_IMPL(a_we_in_write, i_clk, i_rst_n, o_buf.we, r_state == S_WRITE)
    // The byte index never runs past the last byte of the frame.
    `CFPR_ASSERT_IMPL(a_bidx_bound, i_clk, i_rst_n, r_state == S_WRITE, r_bidx <= r_bend)
    // An accepted item leaves the idle state at once.
    `CFPR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && o_ready, r_state != S_IDLE)
    // A result handoff returns the sequencer to idle.
    `CFPR_ASSERT_NEXT(a_ack_idle, i_clk, i_rst_n, o_res_valid && i_res_ack, o_ready)

endmodule

### src/can_fast_packet_reassembler.sv
// ============================================================================
// CAN fast-packet reassembler
// Rebuilds multi-frame fast-packet messages from CAN frames into a byte buffer.
// ============================================================================
// Usage:
// Input items arrive on the s_axis channel. tuser selects the action: 0 stores
// a frame, 1 reads one byte of the message buffer at read_index. Every input
// item gives exactly one result item on m_axis with the message status, the
// PGN and length of the last completed message, the read byte and four
// wrapping counters (frames, messages, sequence errors, cancels).
// After the input accept the sequencer steps through its states before the
// result reaches the m_axis output register: a read or an error frame goes
// straight to the result, a single frame writes its bytes and a start or
// continuation frame its payload bytes (a continuation then checks for
// completion). The next item is accepted once the result is handed over. The
// byte sequencer writes one buffer byte per cycle; one item is worked on at a
// time and s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls with that register full, the sequencer
// holds its result and accepts nothing more until m_axis_tready rises.
// Synchronous reset clears the message state and counters; buffer contents
// are undefined until written.
// ============================================================================
`timescale 1ns / 1ps

module can_fast_packet_reassembler #(
    parameter int BUF_DEPTH      = cfpr_pkg::CFPR_BUF_DEPTH,
    parameter int FAST_LIST_SIZE = cfpr_pkg::CFPR_FAST_LIST_SIZE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // frame_pgn[18:0], frame_len[22:19], payload[86:23], ninth_byte[94:87],
    // read_index[102:95], zero pad[103]
    input  logic [103:0]  s_axis_tdata,
    // action[0]
    input  logic          s_axis_tuser,
    // Result items
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // msg_status[1:0], msg_pgn[20:2], msg_len[28:21], read_byte[36:29],
    // frames_seen[68:37], messages_done[100:69], sequence_errors[132:101],
    // cancelled_messages[164:133], zero pad[167:165]
    output logic [167:0]  m_axis_tdata
);
    import cfpr_pkg::*;

    logic     seq_ready;
    logic     start;
    logic     res_valid;
    logic     res_ack;
    t_result  res;
    t_buf_req buf_req;
    logic [7:0] rd_data;

    logic     r_out_valid;
    t_result  r_out;

    assign start         = s_axis_tvalid && seq_ready;
    assign s_axis_tready = seq_ready;

    // Hand the result over when the output register is free or being emptied.
    assign res_ack = res_valid && (!r_out_valid || m_axis_tready);

    cfpr_seq #(
        .BUF_DEPTH      (BUF_DEPTH),
        .FAST_LIST_SIZE (FAST_LIST_SIZE)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (s_axis_tuser),
        .i_frame_pgn  (s_axis_tdata[18:0]),
        .i_frame_len  (s_axis_tdata[22:19]),
        .i_payload    (s_axis_tdata[86:23]),
        .i_ninth_byte (s_axis_tdata[94:87]),
        .i_read_index (s_axis_tdata[102:95]),
        .o_ready      (seq_ready),
        .o_res_valid  (res_valid),
        .i_res_ack    (res_ack),
        .o_res        (res),
        .o_buf        (buf_req),
        .i_rd_data    (rd_data)
    );

    cfpr_buf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_req     (buf_req),
        .o_rd_data (rd_data)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule
